### hdl/brfe_pkg.sv
package brfe_pkg;

  // Parser phases over the fields of a BAM alignment record, plus a discard phase.
  typedef enum logic [3:0] {
    PH_BLOCK,
    PH_CORE,
    PH_NAME,
    PH_CIGAR,
    PH_SEQ,
    PH_QUAL,
    PH_TAG,
    PH_FIXED,
    PH_STRING,
    PH_SUBTYPE,
    PH_COUNT,
    PH_BSKIP,
    PH_DISCARD
  } phase_t;

  // Result kinds.
  localparam logic [3:0] K_BASE      = 4'd0;
  localparam logic [3:0] K_BARCODE   = 4'd1;
  localparam logic [3:0] K_UMI       = 4'd2;
  localparam logic [3:0] K_NH        = 4'd3;
  localparam logic [3:0] K_BC_DONE   = 4'd4;
  localparam logic [3:0] K_UMI_DONE  = 4'd5;
  localparam logic [3:0] K_REC_END   = 4'd6;
  localparam logic [3:0] K_BAD_TYPE  = 4'd7;
  localparam logic [3:0] K_BAD_SUB   = 4'd8;
  localparam logic [3:0] K_TOO_LONG  = 4'd9;

  // String capture targets.
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_BARCODE = 2'd1;
  localparam logic [1:0] TGT_UMI     = 2'd2;

  localparam logic [31:0] CORE_LAST  = 32'd31;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

  // Tag names, first byte in the low half.
  localparam logic [15:0] TAG_CR = {8'h52, 8'h43};
  localparam logic [15:0] TAG_UR = {8'h52, 8'h55};
  localparam logic [15:0] TAG_NH = {8'h48, 8'h4E};

  // One slot of a result beat.
  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
  } result_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } bundle_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Where the skip chain lands after a header field.
  typedef struct packed {
    phase_t      ph;
    logic [31:0] skip;
  } entry_t;

  // Packed 4-bit base code to ASCII letter.
  function automatic logic [7:0] base_letter(input logic [3:0] code);
    logic [7:0] r;
    case (code)
      4'd0:  r = "=";
      4'd1:  r = "A";
      4'd2:  r = "C";
      4'd3:  r = "M";
      4'd4:  r = "G";
      4'd5:  r = "R";
      4'd6:  r = "S";
      4'd7:  r = "V";
      4'd8:  r = "T";
      4'd9:  r = "W";
      4'd10: r = "Y";
      4'd11: r = "H";
      4'd12: r = "K";
      4'd13: r = "D";
      4'd14: r = "B";
      default: r = "N";
    endcase
    return r;
  endfunction

  // Byte size of a fixed numeric type code, zero when it is not one.
  function automatic logic [2:0] fixed_size(input logic [7:0] t);
    logic [2:0] r;
    case (t)
      "c", "C":      r = 3'd1;
      "s", "S":      r = 3'd2;
      "i", "I", "f": r = 3'd4;
      default:       r = 3'd0;
    endcase
    return r;
  endfunction

  // Walk past empty variable fields, starting at the given one.
  function automatic entry_t enter_from(input phase_t start, input logic [7:0] nl,
                                        input logic [15:0] cc, input logic [31:0] sl);
    entry_t e;
    e.ph   = PH_TAG;
    e.skip = 32'd0;
    if (start == PH_NAME && nl != 8'd0) begin
      e.ph = PH_NAME;
      e.skip = {24'd0, nl};
    end else if ((start == PH_NAME || start == PH_CIGAR) && cc != 16'd0) begin
      e.ph = PH_CIGAR;
      e.skip = {14'd0, cc, 2'b00};
    end else if ((start == PH_NAME || start == PH_CIGAR || start == PH_SEQ) &&
                 sl != 32'd0) begin
      e.ph = PH_SEQ;
      e.skip = (sl >> 1) + {31'd0, sl[0]};
    end else if (start != PH_TAG && sl != 32'd0) begin
      e.ph = PH_QUAL;
      e.skip = sl;
    end
    return e;
  endfunction

endpackage

### hdl/brfe_front.sv
module brfe_front #(
  parameter int BARCODE_MAX = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       max_seq_len,
  output logic              push,
  output brfe_pkg::bundle_t bundle
);
  import brfe_pkg::*;

  localparam int CNT_W = $clog2(BARCODE_MAX + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BARCODE_MAX);

  phase_t            phase, phase_next;
  logic [31:0]       record_offset, record_offset_next;
  logic [2:0]        field_shift, field_shift_next;
  logic [31:0]       record_length, record_length_next;
  logic [7:0]        name_length, name_length_next;
  logic [15:0]       cigar_count, cigar_count_next;
  logic [31:0]       seq_length, seq_length_next;
  logic [31:0]       skip_remaining, skip_remaining_next;
  logic [31:0]       bases_emitted, bases_emitted_next;
  logic [23:0]       tag_and_type, tag_and_type_next;
  logic [1:0]        string_target, string_target_next;
  logic [CNT_W-1:0]  string_count, string_count_next;
  logic [2:0]        element_size, element_size_next;
  logic [31:0]       nh_accumulator, nh_accumulator_next;
  logic [2:0]        nh_bytes_left, nh_bytes_left_next;

  logic        past_core, ends, second_base;
  logic [4:0]  byte_shift;
  logic [31:0] byte_ext, shifted;
  logic [15:0] tag;
  logic [2:0]  type_size;
  entry_t      entry;

  // Shared decode of the current byte.
  assign byte_shift  = {field_shift[1:0], 3'b000};
  assign byte_ext    = {24'd0, data_byte};
  assign shifted     = byte_ext << byte_shift;
  assign tag         = tag_and_type[15:0];
  assign type_size   = (data_byte == "A") ? 3'd1 : fixed_size(data_byte);
  assign past_core   = !(phase == PH_CORE && record_offset < CORE_LAST);
  assign ends        = (phase != PH_BLOCK) && past_core &&
                       ({1'b0, record_offset} + 33'd1 >= {1'b0, record_length});
  assign second_base = !ends && (bases_emitted + 32'd1 < seq_length);

  // Next state of the parser.
  always_comb begin
    logic [31:0] total;
    phase_next          = phase;
    record_offset_next  = record_offset;
    field_shift_next    = field_shift;
    record_length_next  = record_length;
    name_length_next    = name_length;
    cigar_count_next    = cigar_count;
    seq_length_next     = seq_length;
    skip_remaining_next = skip_remaining;
    bases_emitted_next  = bases_emitted;
    tag_and_type_next   = tag_and_type;
    string_target_next  = string_target;
    string_count_next   = string_count;
    element_size_next   = element_size;
    nh_accumulator_next = nh_accumulator;
    nh_bytes_left_next  = nh_bytes_left;
    entry               = enter_from(PH_NAME, name_length, cigar_count, seq_length);
    total               = 32'd0;

    if (accept) begin
      unique case (phase)
        PH_BLOCK: begin
          record_length_next = record_length | shifted;
          field_shift_next = field_shift + 3'd1;
          if (field_shift == 3'd3) begin
            field_shift_next = 3'd0;
            record_offset_next = 32'd0;
            phase_next = PH_CORE;
          end
        end
        PH_CORE: begin
          if (record_offset == 32'd8) name_length_next = data_byte;
          else if (record_offset == 32'd12) cigar_count_next[7:0] = data_byte;
          else if (record_offset == 32'd13) cigar_count_next[15:8] = data_byte;
          else if (record_offset >= 32'd16 && record_offset <= 32'd19)
            seq_length_next = seq_length | (byte_ext << {record_offset[1:0], 3'b000});
          if (record_offset == CORE_LAST) begin
            bases_emitted_next = 32'd0;
            if (seq_length > {16'd0, max_seq_len}) begin
              phase_next = PH_DISCARD;
            end else begin
              entry = enter_from(PH_NAME, name_length, cigar_count, seq_length);
              phase_next = entry.ph;
              skip_remaining_next = entry.skip;
              if (entry.ph == PH_TAG) begin
                field_shift_next = 3'd0;
                tag_and_type_next = 24'd0;
              end
            end
          end
        end
        PH_NAME, PH_CIGAR, PH_QUAL, PH_SEQ: begin
          if (phase == PH_SEQ)
            bases_emitted_next = bases_emitted + (second_base ? 32'd2 : 32'd1);
          skip_remaining_next = skip_remaining - 32'd1;
          if (skip_remaining == 32'd1) begin
            unique case (phase)
              PH_NAME:  entry = enter_from(PH_CIGAR, name_length, cigar_count, seq_length);
              PH_CIGAR: entry = enter_from(PH_SEQ, name_length, cigar_count, seq_length);
              PH_SEQ:   entry = enter_from(PH_QUAL, name_length, cigar_count, seq_length);
              default:  entry = enter_from(PH_TAG, name_length, cigar_count, seq_length);
            endcase
            phase_next = entry.ph;
            skip_remaining_next = entry.skip;
            if (entry.ph == PH_TAG) begin
              field_shift_next = 3'd0;
              tag_and_type_next = 24'd0;
            end
          end
        end
        PH_TAG: begin
          tag_and_type_next = tag_and_type | shifted[23:0];
          field_shift_next = field_shift + 3'd1;
          if (field_shift == 3'd2) begin
            field_shift_next = 3'd0;
            if (type_size != 3'd0) begin
              element_size_next = type_size;
              nh_bytes_left_next = type_size;
              nh_accumulator_next = 32'd0;
              phase_next = PH_FIXED;
            end else if (data_byte == "Z" || data_byte == "H") begin
              string_target_next = (tag == TAG_CR) ? TGT_BARCODE :
                                   (tag == TAG_UR) ? TGT_UMI : TGT_NONE;
              string_count_next = '0;
              phase_next = PH_STRING;
            end else if (data_byte == "B") begin
              phase_next = PH_SUBTYPE;
            end else begin
              phase_next = PH_DISCARD;
            end
          end
        end
        PH_FIXED: begin
          nh_accumulator_next = nh_accumulator | shifted;
          field_shift_next = field_shift + 3'd1;
          nh_bytes_left_next = nh_bytes_left - 3'd1;
          if (nh_bytes_left == 3'd1) begin
            phase_next = PH_TAG;
            field_shift_next = 3'd0;
            tag_and_type_next = 24'd0;
          end
        end
        PH_STRING: begin
          if (data_byte == 8'd0) begin
            string_target_next = TGT_NONE;
            phase_next = PH_TAG;
            field_shift_next = 3'd0;
            tag_and_type_next = 24'd0;
          end else if (string_target != TGT_NONE && string_count < CNT_MAX) begin
            string_count_next = string_count + 1'b1;
          end
        end
        PH_SUBTYPE: begin
          element_size_next = fixed_size(data_byte);
          if (fixed_size(data_byte) == 3'd0) begin
            phase_next = PH_DISCARD;
          end else begin
            field_shift_next = 3'd0;
            skip_remaining_next = 32'd0;
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          skip_remaining_next = skip_remaining | shifted;
          field_shift_next = field_shift + 3'd1;
          if (field_shift == 3'd3) begin
            // Array bytes are count times element size, saturated.
            case (element_size)
              3'd2:    total = skip_remaining_next[31] ? 32'hFFFF_FFFF
                                                       : (skip_remaining_next << 1);
              3'd4:    total = (|skip_remaining_next[31:30]) ? 32'hFFFF_FFFF
                                                             : (skip_remaining_next << 2);
              default: total = skip_remaining_next;
            endcase
            skip_remaining_next = total;
            field_shift_next = 3'd0;
            if (total != 32'd0) begin
              phase_next = PH_BSKIP;
            end else begin
              phase_next = PH_TAG;
              tag_and_type_next = 24'd0;
            end
          end
        end
        PH_BSKIP: begin
          skip_remaining_next = skip_remaining - 32'd1;
          if (skip_remaining == 32'd1) begin
            phase_next = PH_TAG;
            field_shift_next = 3'd0;
            tag_and_type_next = 24'd0;
          end
        end
        default: begin
        end
      endcase

      if (phase != PH_BLOCK) record_offset_next = record_offset + 32'd1;

      // The record's last byte cuts off any field and rearms the parser.
      if (ends) begin
        phase_next = PH_BLOCK;
        field_shift_next = 3'd0;
        record_length_next = 32'd0;
        record_offset_next = 32'd0;
        name_length_next = 8'd0;
        cigar_count_next = 16'd0;
        seq_length_next = 32'd0;
        string_target_next = TGT_NONE;
      end
    end
  end

  // Results caused by the current byte.
  always_comb begin
    result_t r0, r1;
    logic [1:0] n;
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    unique case (phase)
      PH_CORE: begin
        if (record_offset == CORE_LAST && seq_length > {16'd0, max_seq_len}) begin
          r0 = '{kind: K_TOO_LONG, value: seq_length};
          n = 2'd1;
        end
      end
      PH_SEQ: begin
        r0 = '{kind: K_BASE, value: {24'd0, base_letter(data_byte[7:4])}};
        n = 2'd1;
        if (second_base) begin
          r1 = '{kind: K_BASE,
                 value: {24'd0, base_letter(4'(data_byte & NIBBLE_MASK))}};
          n = 2'd2;
        end
      end
      PH_TAG: begin
        if (field_shift == 3'd2 && type_size == 3'd0 && data_byte != "Z" &&
            data_byte != "H" && data_byte != "B") begin
          r0 = '{kind: K_BAD_TYPE, value: byte_ext};
          n = 2'd1;
        end
      end
      PH_FIXED: begin
        if (nh_bytes_left == 3'd1 && tag == TAG_NH) begin
          r0 = '{kind: K_NH, value: nh_accumulator | shifted};
          n = 2'd1;
        end
      end
      PH_STRING: begin
        if (data_byte == 8'd0) begin
          if (string_target != TGT_NONE) begin
            r0 = '{kind: (string_target == TGT_BARCODE) ? K_BC_DONE : K_UMI_DONE,
                   value: 32'(string_count)};
            n = 2'd1;
          end
        end else if (string_target != TGT_NONE && string_count < CNT_MAX) begin
          r0 = '{kind: {2'b00, string_target}, value: byte_ext};
          n = 2'd1;
        end
      end
      PH_SUBTYPE: begin
        if (fixed_size(data_byte) == 3'd0) begin
          r0 = '{kind: K_BAD_SUB, value: byte_ext};
          n = 2'd1;
        end
      end
      default: begin
      end
    endcase

    // Record end follows whatever else this byte caused.
    if (ends) begin
      if (n == 2'd0) r0 = '{kind: K_REC_END, value: bases_emitted_next};
      else r1 = '{kind: K_REC_END, value: bases_emitted_next};
      n = n + 2'd1;
    end
    bundle.count = n;
    bundle.r0 = r0;
    bundle.r1 = r1;
    push = accept && (n != 2'd0);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_BLOCK;
      record_offset  <= 32'd0;
      field_shift    <= 3'd0;
      record_length  <= 32'd0;
      name_length    <= 8'd0;
      cigar_count    <= 16'd0;
      seq_length     <= 32'd0;
      skip_remaining <= 32'd0;
      bases_emitted  <= 32'd0;
      tag_and_type   <= 24'd0;
      string_target  <= TGT_NONE;
      string_count   <= '0;
      element_size   <= 3'd0;
      nh_accumulator <= 32'd0;
      nh_bytes_left  <= 3'd0;
    end else begin
      phase          <= phase_next;
      record_offset  <= record_offset_next;
      field_shift    <= field_shift_next;
      record_length  <= record_length_next;
      name_length    <= name_length_next;
      cigar_count    <= cigar_count_next;
      seq_length     <= seq_length_next;
      skip_remaining <= skip_remaining_next;
      bases_emitted  <= bases_emitted_next;
      tag_and_type   <= tag_and_type_next;
      string_target  <= string_target_next;
      string_count   <= string_count_next;
      element_size   <= element_size_next;
      nh_accumulator <= nh_accumulator_next;
      nh_bytes_left  <= nh_bytes_left_next;
    end
  end

endmodule

### hdl/brfe_queue.sv
module brfe_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  brfe_pkg::bundle_t push_data,
  input  logic              pop,
  output brfe_pkg::bundle_t head,
  output brfe_pkg::qstat_t  stat
);
  import brfe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

### hdl/brfe_back.sv
module brfe_back (
  input  logic              clk,
  input  logic              rst,
  input  brfe_pkg::bundle_t head,
  input  logic              empty,
  input  logic              out_stall,
  output logic              pop,
  output logic              out_valid,
  output logic [3:0]        kind,
  output logic [31:0]       value,
  output logic              last
);
  import brfe_pkg::*;

  // Selects the second result of a two-result bundle.
  logic sel;
  logic beat;

  assign out_valid = !empty;
  assign kind      = sel ? head.r1.kind : head.r0.kind;
  assign value     = sel ? head.r1.value : head.r0.value;
  assign last      = sel || (head.count == 2'd1);
  assign beat      = out_valid && !out_stall;
  assign pop       = beat && last;

  // Step through the bundle one beat at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (beat) begin
      sel <= !last;
    end
  end

endmodule

### hdl/bam_record_field_extractor_unit.sv
// Each byte's results are registered in the result queue and offered from its head.
// Throughput: one byte per cycle while the queue is not full; a byte with two results
// gives two output beats, and the four-entry result queue fills when that repeats.
// Reset: synchronous, active high; clears the parser to await a block size,
// empties the queue and sets max_seq_len to 4096.
module bam_record_field_extractor_unit #(
  parameter int BARCODE_MAX = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [31:0] value,
  output logic        last
);
  import brfe_pkg::*;

  logic [15:0] max_seq_len;
  logic        accept, push, pop;
  bundle_t     bundle, head;
  qstat_t      qstat;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_seq_len <= 16'd4096;
    end else if (cfg_we) begin
      max_seq_len <= cfg_data;
    end
  end

  brfe_front #(.BARCODE_MAX(BARCODE_MAX)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .data_byte(data_byte),
    .max_seq_len(max_seq_len), .push(push), .bundle(bundle)
  );

  brfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(bundle), .pop(pop),
    .head(head), .stat(qstat)
  );

  brfe_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(qstat.empty), .out_stall(out_stall),
    .pop(pop), .out_valid(out_valid), .kind(kind), .value(value), .last(last)
  );

  // A full queue always has a result on offer.
  a_full_offers: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("queue full with no result offered");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result offered after reset");

  // Only defined kinds leave the block.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind <= K_TOO_LONG)) else $error("undefined result kind");

  // A beat that is not last is followed by the rest of its bundle.
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("second result of a byte missing");

endmodule

### sim/bam_record_field_extractor_unit_test.sv
module bam_record_field_extractor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brfe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int STRING_CAP  = 32;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] value;
    logic        last;
  } field_result_t;

  // Scoreboard: tracks the parser state and the results each byte should cause.
  class extract_scoreboard;
    phase_t      ph;
    logic [31:0] rec_off, shift, rec_len, seq_len, skip, bases, tagtype, nh_acc;
    logic [7:0]  name_len;
    logic [15:0] cigar_cnt, max_len;
    logic [1:0]  target;
    int          str_cnt, elem_size, nh_left, errors, checked;
    field_result_t pending_results[$];
    string       letters = "=ACMGRSVTWYHKDBN";

    function void clear();
      max_len = 16'd4096;
      ph = PH_BLOCK;
      rec_off = 0; shift = 0; rec_len = 0; seq_len = 0; skip = 0; bases = 0;
      tagtype = 0; nh_acc = 0; name_len = 0; cigar_cnt = 0; target = TGT_NONE;
      str_cnt = 0; elem_size = 0; nh_left = 0;
    endfunction

    function int type_bytes(logic [7:0] t);
      case (t)
        "c", "C":      return 1;
        "s", "S":      return 2;
        "i", "I", "f": return 4;
        default:       return 0;
      endcase
    endfunction

    // Step past empty variable-length fields, starting at the given one.
    function void walk_fields(phase_t p);
      if (p == PH_NAME) begin
        if (name_len != 0) begin skip = name_len; ph = PH_NAME; return; end
        p = PH_CIGAR;
      end
      if (p == PH_CIGAR) begin
        if (cigar_cnt != 0) begin skip = {cigar_cnt, 2'b00}; ph = PH_CIGAR; return; end
        p = PH_SEQ;
      end
      if (p == PH_SEQ) begin
        if (seq_len != 0) begin
          skip = (seq_len >> 1) + seq_len[0];
          ph = PH_SEQ;
          return;
        end
        p = PH_QUAL;
      end
      if (p == PH_QUAL && seq_len != 0) begin skip = seq_len; ph = PH_QUAL; return; end
      ph = PH_TAG;
      shift = 0;
      tagtype = 0;
    endfunction

    // Note one accepted input byte and queue the results it should cause.
    function void note_byte(logic [7:0] b);
      field_result_t r[$];
      logic past_core, ends;
      logic [63:0] total;
      int sz;
      if (ph == PH_BLOCK) begin
        rec_len |= {24'd0, b} << (8 * shift[1:0]);
        shift++;
        if (shift >= 4) begin shift = 0; rec_off = 0; ph = PH_CORE; end
        return;
      end
      past_core = !(ph == PH_CORE && rec_off + 1 < 32);
      ends = past_core && ({1'b0, rec_off} + 33'd1 >= {1'b0, rec_len});
      case (ph)
        PH_CORE: begin
          if (rec_off == 8) name_len = b;
          else if (rec_off == 12 || rec_off == 13)
            cigar_cnt |= {8'd0, b} << (8 * (rec_off - 12));
          else if (rec_off >= 16 && rec_off <= 19)
            seq_len |= {24'd0, b} << (8 * (rec_off - 16));
          if (rec_off == 31) begin
            bases = 0;
            if (seq_len > {16'd0, max_len}) begin
              r.push_back('{K_TOO_LONG, seq_len, 1'b0});
              ph = PH_DISCARD;
            end else walk_fields(PH_NAME);
          end
        end
        PH_NAME, PH_CIGAR, PH_QUAL: begin
          skip--;
          if (skip == 0)
            walk_fields(ph == PH_NAME ? PH_CIGAR : ph == PH_CIGAR ? PH_SEQ : PH_TAG);
        end
        PH_SEQ: begin
          r.push_back('{K_BASE, {24'd0, letters[b[7:4]]}, 1'b0});
          bases++;
          if (!ends && bases < seq_len) begin
            r.push_back('{K_BASE, {24'd0, letters[b[3:0]]}, 1'b0});
            bases++;
          end
          skip--;
          if (skip == 0) walk_fields(PH_QUAL);
        end
        PH_TAG: begin
          tagtype |= {24'd0, b} << (8 * shift[1:0]);
          shift++;
          if (shift >= 3) begin
            sz = (b == "A") ? 1 : type_bytes(b);
            shift = 0;
            if (sz != 0) begin
              elem_size = sz; nh_left = sz; nh_acc = 0; ph = PH_FIXED;
            end else if (b == "Z" || b == "H") begin
              target = (tagtype[15:0] == TAG_CR) ? TGT_BARCODE :
                       (tagtype[15:0] == TAG_UR) ? TGT_UMI : TGT_NONE;
              str_cnt = 0;
              ph = PH_STRING;
            end else if (b == "B") ph = PH_SUBTYPE;
            else begin
              r.push_back('{K_BAD_TYPE, {24'd0, b}, 1'b0});
              ph = PH_DISCARD;
            end
          end
        end
        PH_FIXED: begin
          nh_acc |= {24'd0, b} << (8 * shift[1:0]);
          shift++;
          nh_left--;
          if (nh_left == 0) begin
            if (tagtype[15:0] == TAG_NH) r.push_back('{K_NH, nh_acc, 1'b0});
            ph = PH_TAG; shift = 0; tagtype = 0;
          end
        end
        PH_STRING: begin
          if (b == 0) begin
            if (target != TGT_NONE)
              r.push_back('{(target == TGT_BARCODE) ? K_BC_DONE : K_UMI_DONE,
                            str_cnt, 1'b0});
            target = TGT_NONE;
            ph = PH_TAG; shift = 0; tagtype = 0;
          end else if (target != TGT_NONE && str_cnt < STRING_CAP) begin
            r.push_back('{{2'b00, target}, {24'd0, b}, 1'b0});
            str_cnt++;
          end
        end
        PH_SUBTYPE: begin
          elem_size = type_bytes(b);
          if (elem_size == 0) begin
            r.push_back('{K_BAD_SUB, {24'd0, b}, 1'b0});
            ph = PH_DISCARD;
          end else begin
            shift = 0; skip = 0; ph = PH_COUNT;
          end
        end
        PH_COUNT: begin
          skip |= {24'd0, b} << (8 * shift[1:0]);
          shift++;
          if (shift >= 4) begin
            total = {32'd0, skip} * elem_size;
            skip = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
            shift = 0;
            if (skip != 0) ph = PH_BSKIP;
            else begin ph = PH_TAG; tagtype = 0; end
          end
        end
        PH_BSKIP: begin
          skip--;
          if (skip == 0) begin ph = PH_TAG; shift = 0; tagtype = 0; end
        end
        default: ;
      endcase
      rec_off++;
      if (ends) begin
        r.push_back('{K_REC_END, bases, 1'b0});
        ph = PH_BLOCK; shift = 0; rec_len = 0; rec_off = 0;
        name_len = 0; cigar_cnt = 0; seq_len = 0; target = TGT_NONE;
      end
      if (r.size() > 0) r[r.size() - 1].last = 1'b1;
      foreach (r[i]) pending_results.push_back(r[i]);
    endfunction

    // Compare one result beat with the oldest expectation.
    function void check_result(logic [3:0] k, logic [31:0] v, logic l);
      field_result_t e;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d value %0h last %0b", $time, k, v, l);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      if (k !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
        errors++;
      end
      if (v !== e.value) begin
        $display("%0t: value expected %0h actual %0h", $time, e.value, v);
        errors++;
      end
      if (l !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, l);
        errors++;
      end
    endfunction
  endclass

  typedef enum {
    REC_NORMAL, REC_ALLTAGS, REC_CUT, REC_TRUNC, REC_SHORT,
    REC_LONG, REC_BADTYPE, REC_BADSUB, REC_NOISE
  } rec_mode_t;

  logic        clk, rst;
  logic        in_valid, in_stall;
  logic [7:0]  data_byte;
  logic        cfg_we;
  logic [15:0] cfg_data;
  logic        out_valid, out_stall;
  logic [3:0]  kind;
  logic [31:0] value;
  logic        last;

  extract_scoreboard sb;
  logic [7:0] rec_bytes[$];
  int  bytes_sent, records_sent, cycles, stall_left;
  bit  calm;

  bam_record_field_extractor_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .value(value), .last(last)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'd0;
    cfg_we = 1'b0;
    cfg_data = 16'd0;
    out_stall = 1'b0;
  end

  always #6 clk = ~clk;

  // Cycle count and timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 14);
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(kind, value, last);
  end

  // Send one byte, with an occasional idle burst before it.
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_record();
    foreach (rec_bytes[i]) send_byte(rec_bytes[i]);
    records_sent++;
  endtask

  // Change the length limit once the block has drained.
  task automatic set_max_len(input logic [15:0] v);
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_len = v;
  endtask

  function automatic void push32(ref logic [7:0] q[$], input logic [31:0] v);
    for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [7:0] any_fixed_type();
    string types = "cCsSiIfA";
    return types[$urandom_range(0, 7)];
  endfunction

  // Append one aux field of the given flavor.
  function automatic void add_tag(ref logic [7:0] q[$], input int flavor);
    logic [7:0] t;
    int n, sz;
    case (flavor)
      0, 4: begin
        if (flavor == 0) begin q.push_back("N"); q.push_back("H"); end
        else begin q.push_back("X"); q.push_back("A"); end
        t = any_fixed_type();
        q.push_back(t);
        sz = (t == "A") ? 1 : sb.type_bytes(t);
        repeat (sz) q.push_back(8'($urandom_range(0, 255)));
      end
      1, 2, 3: begin
        if (flavor == 1) begin q.push_back("C"); q.push_back("R"); end
        else if (flavor == 2) begin q.push_back("U"); q.push_back("R"); end
        else begin q.push_back("X"); q.push_back("Z"); end
        q.push_back($urandom_range(0, 1) ? "Z" : "H");
        n = (flavor == 3) ? $urandom_range(0, 5) :
            ($urandom_range(0, 3) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
        repeat (n) q.push_back(8'($urandom_range(1, 255)));
        q.push_back(8'd0);
      end
      default: begin
        q.push_back("X"); q.push_back("B"); q.push_back("B");
        t = any_fixed_type();
        if (t == "A") t = "c";
        q.push_back(t);
        n = $urandom_range(0, 3);
        push32(q, n);
        repeat (n * sb.type_bytes(t)) q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // Build one record, size field included, into rec_bytes.
  function automatic void build_record(input rec_mode_t mode);
    logic [7:0] body[$];
    logic [7:0] t;
    logic [31:0] bsize, lfield;
    int nl, cc, sl, span;
    nl = $urandom_range(0, 6);
    cc = $urandom_range(0, 2);
    sl = (mode == REC_CUT) ? $urandom_range(2, 9) : $urandom_range(0, 9);
    lfield = sl;
    if (mode == REC_LONG)
      lfield = (sb.max_len == 16'hFFFF || $urandom_range(0, 3) == 0) ?
               (32'h0001_0000 | $urandom) : sb.max_len + $urandom_range(1, 5);
    repeat (32) body.push_back(8'($urandom_range(0, 255)));
    body[8] = nl[7:0];
    body[12] = cc[7:0];
    body[13] = 8'd0;
    for (int i = 0; i < 4; i++) body[16 + i] = lfield[8*i +: 8];
    repeat (nl + 4 * cc + (sl + 1) / 2 + sl) body.push_back(8'($urandom_range(0, 255)));
    if (mode == REC_ALLTAGS) for (int k = 0; k < 6; k++) add_tag(body, k);
    else repeat ($urandom_range(0, 4)) add_tag(body, $urandom_range(0, 5));
    // Broken tails: a bad type, a bad array subtype, or plain garbage.
    if (mode == REC_BADTYPE || mode == REC_BADSUB) begin
      body.push_back("X"); body.push_back("Q");
      if (mode == REC_BADSUB) body.push_back("B");
      do t = 8'($urandom_range(0, 255));
      while (sb.type_bytes(t) != 0 || t == "A" ||
             (mode == REC_BADTYPE && (t == "Z" || t == "H" || t == "B")));
      body.push_back(t);
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 255)));
    end else if (mode == REC_NOISE)
      repeat ($urandom_range(1, 12)) body.push_back(8'($urandom_range(0, 255)));
    bsize = body.size();
    case (mode)
      REC_CUT:   bsize = 32 + nl + 4 * cc + $urandom_range(1, (sl + 1) / 2);
      REC_TRUNC: bsize = $urandom_range(32, body.size());
      REC_SHORT: bsize = $urandom_range(0, 31);
      default: ;
    endcase
    span = (bsize < 32) ? 32 : bsize;
    while (body.size() > span) void'(body.pop_back());
    rec_bytes.delete();
    push32(rec_bytes, bsize);
    foreach (body[i]) rec_bytes.push_back(body[i]);
  endfunction

  // Mostly well-formed records, with some broken ones mixed in.
  task automatic random_records(input int byte_goal);
    rec_mode_t m;
    int pick;
    while (bytes_sent < byte_goal) begin
      pick = $urandom_range(0, 19);
      m = (pick < 12) ? REC_NORMAL : (pick == 12) ? REC_ALLTAGS : (pick == 13) ? REC_CUT :
          (pick == 14) ? REC_TRUNC : (pick == 15) ? REC_SHORT : (pick == 16) ? REC_LONG :
          (pick == 17) ? REC_BADTYPE : (pick == 18) ? REC_BADSUB : REC_NOISE;
      build_record(m);
      send_record();
    end
  endtask

  initial begin
    rec_mode_t directed[$];
    sb = new();
    sb.clear();
    cycles = 0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed records at the reset limit: short, all-tags, cut, long, bad type, bad subtype.
    directed = '{REC_SHORT, REC_ALLTAGS, REC_CUT, REC_LONG, REC_BADTYPE, REC_BADSUB};
    foreach (directed[i]) begin
      build_record(directed[i]);
      send_record();
    end

    // Random records over several limit settings, extremes included.
    random_records(300);
    set_max_len(16'd1);
    random_records(550);
    set_max_len(16'hFFFF);
    random_records(800);
    set_max_len(16'($urandom_range(2, 8)));
    random_records(1050);
    set_max_len(16'd4096);
    random_records(1300);
    calm = 1'b1;
    random_records(1450);

    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d records; checked %0d result beats.",
             bytes_sent, records_sent, sb.checked);
    $display("Limits 4096, 1, 65535, a small random one and 4096 again were used.");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### bam_record_field_extractor_unit.f
hdl/brfe_pkg.sv
hdl/brfe_front.sv
hdl/brfe_queue.sv
hdl/brfe_back.sv
hdl/bam_record_field_extractor_unit.sv
sim/bam_record_field_extractor_unit_test.sv
